[sv/lgs_pkg.sv]
package lgs_pkg;

	// largest grid side the line stores are sized for
	localparam int MAX_SIDE = 32;
	localparam int PORT_RESULTS = 33;
	localparam int SIDE_MIN = 3;
	// the side tops out at the smaller of MAX_SIDE and PORT_RESULTS - 2
	localparam int SIDE_MAX = (MAX_SIDE < PORT_RESULTS - 2) ? MAX_SIDE : PORT_RESULTS - 2;

	localparam int GRID_W = 6;
	localparam int SIDE_W = $clog2(SIDE_MAX + 1);
	localparam int LINE_DEPTH = SIDE_MAX + 1;
	localparam logic [GRID_W-1:0] GRID_RESET = GRID_W'(32);

	localparam int COUNT_W = 4;
	localparam logic [COUNT_W-1:0] SURVIVE_COUNT = COUNT_W'(2);
	localparam logic [COUNT_W-1:0] BIRTH_COUNT = COUNT_W'(3);

	typedef struct packed {
		logic step;
		logic clr;
	} lgs_ctl_t;

	typedef struct packed {
		logic top;
		logic mid;
		logic bot;
	} lgs_col_t;

	typedef struct packed {
		logic next_cell;
		logic last_out;
	} lgs_res_t;

	function automatic logic [SIDE_W-1:0] clamp_side(input logic [GRID_W-1:0] w);
		logic [SIDE_W-1:0] s;
		if (w < GRID_W'(SIDE_MIN)) begin
			s = SIDE_W'(SIDE_MIN);
		end else if (w > GRID_W'(SIDE_MAX)) begin
			s = SIDE_W'(SIDE_MAX);
		end else begin
			s = w[SIDE_W-1:0];
		end
		return s;
	endfunction

endpackage

[sv/lgs_if.sv]
interface lgs_in_if;
	logic valid;
	logic ready;
	logic cell_value;
	logic frame_end;

	modport source(output valid, cell_value, frame_end, input ready);
	modport sink(input valid, cell_value, frame_end, output ready);
endinterface

interface lgs_out_if;
	logic valid;
	logic ready;
	logic next_cell;
	logic last_out;

	modport source(output valid, next_cell, last_out, input ready);
	modport sink(input valid, next_cell, last_out, output ready);
endinterface

[sv/lgs_cell.sv]
module lgs_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  lgs_pkg::lgs_ctl_t ctl,
	input  logic              d,
	output logic              q
);

	logic bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q <= 1'b0;
		end else if (ctl.clr) begin
			bit_q <= 1'b0;
		end else if (ctl.step) begin
			bit_q <= d;
		end
	end

	assign q = bit_q;

endmodule

[sv/lgs_line.sv]
module lgs_line (
	input  logic                       clk,
	input  logic                       arst_n,
	input  lgs_pkg::lgs_ctl_t          ctl,
	input  logic [lgs_pkg::SIDE_W-1:0] side,
	input  logic                       d,
	output logic                       tap
);

	logic [lgs_pkg::LINE_DEPTH-1:0] chain;

	lgs_cell u_head (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.d      (d),
		.q      (chain[0])
	);

	for (genvar k = 1; k < lgs_pkg::LINE_DEPTH; k++) begin : g_cell
		lgs_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.d      (chain[k-1]),
			.q      (chain[k])
		);
	end

	// one row is side + 1 steps, so the same column of the previous row sits at index side
	assign tap = chain[side];

endmodule

[sv/lgs_window.sv]
module lgs_window (
	input  logic              clk,
	input  logic              arst_n,
	input  lgs_pkg::lgs_ctl_t ctl,
	input  lgs_pkg::lgs_col_t col_new,
	output logic              alive
);

	lgs_pkg::lgs_col_t col1_q;
	lgs_pkg::lgs_col_t col2_q;
	logic [lgs_pkg::COUNT_W-1:0] count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col1_q <= '0;
			col2_q <= '0;
		end else if (ctl.clr) begin
			col1_q <= '0;
			col2_q <= '0;
		end else if (ctl.step) begin
			col1_q <= col_new;
			col2_q <= col1_q;
		end
	end

	// centre is the middle of the column one step back, eight around it
	always_comb begin
		count = lgs_pkg::COUNT_W'(col2_q.top) + lgs_pkg::COUNT_W'(col2_q.mid)
			+ lgs_pkg::COUNT_W'(col2_q.bot) + lgs_pkg::COUNT_W'(col1_q.top)
			+ lgs_pkg::COUNT_W'(col1_q.bot) + lgs_pkg::COUNT_W'(col_new.top)
			+ lgs_pkg::COUNT_W'(col_new.mid) + lgs_pkg::COUNT_W'(col_new.bot);
		alive = (count == lgs_pkg::BIRTH_COUNT)
			|| (col1_q.mid && (count == lgs_pkg::SURVIVE_COUNT));
	end

endmodule

[sv/life_generation_stencil.sv]
// Life generation stencil, rule B3/S23, on a square grid of side S.
// cur_gen takes current-generation cells in raster order, one beat per cell.
// next_gen gives next-generation cells in raster order, last_out on the
// final cell of the grid. cfg_we/cfg_wdata write the grid side; values
// below 3 act as 3, values above 31 act as 31. A write restarts the frame.
// Each row runs S + 1 steps: S input beats plus one internal step for the
// dead column past the right edge. After the last input beat a row of S + 1
// internal steps drain the bottom row; cur_gen.ready is low in those steps.
// Cell (a,b) is computed on the step of input (a+1,b+1) and written to the
// output buffer feeding next_gen. The window is set by two shift-chain line
// stores of SIDE_MAX + 1 cells each, tapped at S, and an eight-input count.
// Reset clears all stores to dead, sets the side to 31 and waits for cell
// (0,0). A two-beat output buffer decouples the sides: when next_gen stalls,
// the buffer fills and cur_gen.ready drops until a beat is taken.
module life_generation_stencil (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [lgs_pkg::GRID_W-1:0] cfg_wdata,
	lgs_in_if.sink                     cur_gen,
	lgs_out_if.source                  next_gen
);

	logic [lgs_pkg::SIDE_W-1:0] side_q;
	logic [lgs_pkg::SIDE_W-1:0] col_q;
	logic [lgs_pkg::SIDE_W-1:0] row_q;

	lgs_pkg::lgs_res_t buf_q [2];
	logic              wr_q;
	logic              rd_q;
	logic [1:0]        cnt_q;

	logic              real_step;
	logic              buf_full;
	logic              step_go;
	logic              step_val;
	logic              emit;
	logic              frame_last;
	logic              push;
	logic              pop;
	logic              mid_tap;
	logic              up_tap;
	logic              alive;
	lgs_pkg::lgs_ctl_t ctl;
	lgs_pkg::lgs_col_t col_new;

	assign real_step  = (col_q != side_q) && (row_q != side_q);
	assign buf_full   = (cnt_q == 2'd2);
	assign step_go    = !buf_full && (!real_step || cur_gen.valid);
	assign step_val   = real_step && cur_gen.cell_value;
	assign emit       = (row_q != '0) && (col_q != '0);
	assign frame_last = (row_q == side_q) && (col_q == side_q);

	assign cur_gen.ready = real_step && !buf_full;

	assign ctl.step = step_go;
	assign ctl.clr  = cfg_we || (step_go && frame_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q <= lgs_pkg::clamp_side(lgs_pkg::GRID_RESET);
			col_q  <= '0;
			row_q  <= '0;
		end else if (cfg_we) begin
			side_q <= lgs_pkg::clamp_side(cfg_wdata);
			col_q  <= '0;
			row_q  <= '0;
		end else if (step_go) begin
			if (frame_last) begin
				col_q <= '0;
				row_q <= '0;
			end else if (col_q == side_q) begin
				col_q <= '0;
				row_q <= row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	lgs_line u_mid_line (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.side   (side_q),
		.d      (step_val),
		.tap    (mid_tap)
	);

	lgs_line u_up_line (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.side   (side_q),
		.d      (mid_tap),
		.tap    (up_tap)
	);

	assign col_new.top = up_tap;
	assign col_new.mid = mid_tap;
	assign col_new.bot = step_val;

	lgs_window u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.col_new (col_new),
		.alive   (alive)
	);

	// two-beat output buffer
	assign push = step_go && emit;
	assign pop  = next_gen.valid && next_gen.ready;

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_q].next_cell <= alive;
			buf_q[wr_q].last_out  <= frame_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (!push && pop) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	assign next_gen.valid     = (cnt_q != 2'd0);
	assign next_gen.next_cell = buf_q[rd_q].next_cell;
	assign next_gen.last_out  = buf_q[rd_q].last_out;

`ifndef SYNTHESIS
	a_buf_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("output buffer count out of range");

	a_last_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		(push && frame_last && !cfg_we) |=> (col_q == '0) && (row_q == '0))
		else $error("frame did not restart after the final result");

	a_cfg_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> (col_q == '0) && (row_q == '0))
		else $error("register write did not restart the frame");

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		buf_full |-> !push)
		else $error("result pushed into a full output buffer");
`endif

endmodule
